// ===== hdl/rihc_pkg.sv =====
// Shared types, status codes and limits for the relocatable image header checker.
`timescale 1ns / 1ps
`default_nettype none
package rihc_pkg;

  localparam int unsigned CountW = 20;
  localparam int unsigned OffsW  = 19;

  localparam logic [CountW-1:0] SEEN_MAX = 20'hFFFFF;
  localparam logic [CountW-1:0] HDR_LEN  = 20'd12;
  localparam logic [7:0]        MAGIC_0  = 8'h58;
  localparam logic [7:0]        MAGIC_1  = 8'h4C;
  localparam logic [7:0]        VERSION_ONE = 8'd1;

  localparam logic [3:0] POS_MAGIC_0   = 4'd0;
  localparam logic [3:0] POS_MAGIC_1   = 4'd1;
  localparam logic [3:0] POS_VERSION   = 4'd2;
  localparam logic [3:0] POS_FLAGS     = 4'd3;
  localparam logic [3:0] POS_ENTRY_LO  = 4'd4;
  localparam logic [3:0] POS_ENTRY_HI  = 4'd5;
  localparam logic [3:0] POS_CSIZE_LO  = 4'd6;
  localparam logic [3:0] POS_CSIZE_HI  = 4'd7;
  localparam logic [3:0] POS_RCOUNT_LO = 4'd8;
  localparam logic [3:0] POS_RCOUNT_HI = 4'd9;

  localparam logic [1:0] REC_OFFS_LO = 2'd0;
  localparam logic [1:0] REC_OFFS_HI = 2'd1;
  localparam logic [1:0] REC_WIDTH   = 2'd2;
  localparam logic [1:0] REC_PAD     = 2'd3;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NOT_IMAGE   = 3'd1;
  localparam logic [2:0] ST_BAD_VERSION = 3'd2;
  localparam logic [2:0] ST_SIZE_MISM   = 3'd3;
  localparam logic [2:0] ST_ENTRY_OUT   = 3'd4;
  localparam logic [2:0] ST_RELOC_BAD   = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [7:0]        version;
    logic [7:0]        header_flags;
    logic [15:0]       entry_offset;
    logic [15:0]       code_length;
    logic [15:0]       reloc_total;
    logic [OffsW-1:0]  code_start;
    logic [OffsW-1:0]  expected_length;
    logic [CountW-1:0] seen_length;
    logic [15:0]       bad_reloc_index;
  } out_t;

  typedef struct packed {
    logic        magic_good;
    logic [7:0]  version;
    logic [7:0]  flags;
    logic [15:0] entry;
    logic [15:0] code_len;
    logic [15:0] reloc_count;
    logic        reloc_fault;
    logic [15:0] first_bad;
  } hdr_t;

  localparam hdr_t HDR_RESET = '{
    magic_good:  1'b1,
    version:     8'd0,
    flags:       8'd0,
    entry:       16'd0,
    code_len:    16'd0,
    reloc_count: 16'd0,
    reloc_fault: 1'b0,
    first_bad:   16'd0
  };

endpackage
`default_nettype wire

// ===== hdl/rihc_verdict.sv =====
// Verdict logic: status priority and result word assembly from captured header state.
`timescale 1ns / 1ps
`default_nettype none
module rihc_verdict (
  input  wire rihc_pkg::hdr_t                     hdr,
  input  wire logic [rihc_pkg::CountW-1:0]        seen,
  output rihc_pkg::out_t                          result
);

  logic [rihc_pkg::OffsW-1:0] cstart;
  logic [rihc_pkg::OffsW-1:0] expect_len;
  logic [2:0]                 status;

  always_comb begin
    cstart     = rihc_pkg::OffsW'(rihc_pkg::HDR_LEN) + {1'b0, hdr.reloc_count, 2'b00};
    expect_len = cstart + {3'b000, hdr.code_len};

    if ((seen < rihc_pkg::HDR_LEN) || !hdr.magic_good) begin
      status = rihc_pkg::ST_NOT_IMAGE;
    end else if (hdr.version != rihc_pkg::VERSION_ONE) begin
      status = rihc_pkg::ST_BAD_VERSION;
    end else if ({1'b0, expect_len} != seen) begin
      status = rihc_pkg::ST_SIZE_MISM;
    end else if ((hdr.code_len == 16'd0) || (hdr.entry >= hdr.code_len)) begin
      status = rihc_pkg::ST_ENTRY_OUT;
    end else if (hdr.reloc_fault) begin
      status = rihc_pkg::ST_RELOC_BAD;
    end else begin
      status = rihc_pkg::ST_OK;
    end

    result        = '0;
    result.status = status;
    if (status != rihc_pkg::ST_NOT_IMAGE) begin
      result.version         = hdr.version;
      result.header_flags    = hdr.flags;
      result.entry_offset    = hdr.entry;
      result.code_length     = hdr.code_len;
      result.reloc_total     = hdr.reloc_count;
      result.code_start      = cstart;
      result.expected_length = expect_len;
    end
    result.seen_length = seen;
    if (status == rihc_pkg::ST_RELOC_BAD) begin
      result.bad_reloc_index = hdr.first_bad;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/relocatable_image_header_checker.sv =====
// Top level: byte-stream parser, header and relocation checks, registered verdict output.
//
// Usage:
//   Feed an image one byte per word on the in_ channel (valid/ready), with
//   in_data.last set on its final byte. Header fields are captured and each
//   relocation record is checked as it streams past.
//   One verdict word appears on the out_ channel for each image, in the cycle
//   after its last byte is accepted.
//   Throughput is one byte per cycle while no last byte waits; the only cost
//   per byte is the header capture, the record compare and the byte counter update.
//   The verdict sits in a single output register. While it waits for
//   out_ready, bytes that are not last are still accepted; a last byte waits
//   until the register frees or drains in that same cycle.
//   Reset (rst_n low, synchronous) clears the parser state and drops any
//   pending verdict. After each verdict the parser returns to its reset state,
//   ready for the next image.
`timescale 1ns / 1ps
`default_nettype none
module relocatable_image_header_checker (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output      logic            in_ready,
  input  wire rihc_pkg::in_t   in_data,
  output      logic            out_valid,
  input  wire logic            out_ready,
  output      rihc_pkg::out_t  out_data
);

  rihc_pkg::hdr_t                  hdr_r, hdr_nxt;
  logic [rihc_pkg::CountW-1:0]     byte_count_r, byte_count_nxt;
  logic [15:0]                     rec_index_r, rec_index_nxt;
  logic [15:0]                     rec_offset_r, rec_offset_nxt;
  logic                            out_valid_r;
  rihc_pkg::out_t                  out_data_r;
  rihc_pkg::out_t                  verdict;

  logic                            in_acc;
  logic [7:0]                      b;
  logic [15:0]                     room;
  logic                            rec_bad;

  assign in_ready  = !out_valid_r || out_ready || !in_data.last;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign b         = in_data.data_byte;

  always_comb begin
    hdr_nxt        = hdr_r;
    rec_index_nxt  = rec_index_r;
    rec_offset_nxt = rec_offset_r;
    room           = hdr_r.code_len - rec_offset_r;
    rec_bad        = ((b != 8'd1) && (b != 8'd2)) || (rec_offset_r >= hdr_r.code_len) ||
                     ({8'd0, b} > room);

    if (byte_count_r < rihc_pkg::HDR_LEN) begin
      case (byte_count_r[3:0])
        rihc_pkg::POS_MAGIC_0: begin
          if (b != rihc_pkg::MAGIC_0) hdr_nxt.magic_good = 1'b0;
        end
        rihc_pkg::POS_MAGIC_1: begin
          if (b != rihc_pkg::MAGIC_1) hdr_nxt.magic_good = 1'b0;
        end
        rihc_pkg::POS_VERSION:   hdr_nxt.version           = b;
        rihc_pkg::POS_FLAGS:     hdr_nxt.flags             = b;
        rihc_pkg::POS_ENTRY_LO:  hdr_nxt.entry[7:0]        = b;
        rihc_pkg::POS_ENTRY_HI:  hdr_nxt.entry[15:8]       = b;
        rihc_pkg::POS_CSIZE_LO:  hdr_nxt.code_len[7:0]     = b;
        rihc_pkg::POS_CSIZE_HI:  hdr_nxt.code_len[15:8]    = b;
        rihc_pkg::POS_RCOUNT_LO: hdr_nxt.reloc_count[7:0]  = b;
        rihc_pkg::POS_RCOUNT_HI: hdr_nxt.reloc_count[15:8] = b;
        default: ;
      endcase
    end else if (rec_index_r < hdr_r.reloc_count) begin
      case (byte_count_r[1:0])
        rihc_pkg::REC_OFFS_LO: rec_offset_nxt = {8'd0, b};
        rihc_pkg::REC_OFFS_HI: rec_offset_nxt = {b, rec_offset_r[7:0]};
        rihc_pkg::REC_WIDTH: begin
          if (rec_bad && !hdr_r.reloc_fault) begin
            hdr_nxt.reloc_fault = 1'b1;
            hdr_nxt.first_bad   = rec_index_r;
          end
        end
        rihc_pkg::REC_PAD:     rec_index_nxt = rec_index_r + 16'd1;
        default: ;
      endcase
    end

    byte_count_nxt = (byte_count_r < rihc_pkg::SEEN_MAX) ? byte_count_r + 1'b1 : byte_count_r;
  end

  rihc_verdict u_verdict (
    .hdr    (hdr_nxt),
    .seen   (byte_count_nxt),
    .result (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r        <= rihc_pkg::HDR_RESET;
      byte_count_r <= '0;
      rec_index_r  <= '0;
      rec_offset_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        if (in_data.last) begin
          hdr_r        <= rihc_pkg::HDR_RESET;
          byte_count_r <= '0;
          rec_index_r  <= '0;
          rec_offset_r <= '0;
        end else begin
          hdr_r        <= hdr_nxt;
          byte_count_r <= byte_count_nxt;
          rec_index_r  <= rec_index_nxt;
          rec_offset_r <= rec_offset_nxt;
        end
      end
      if (in_acc && in_data.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_data.last) begin
      out_data_r <= verdict;
    end
  end

  a_last_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.last) |=> (out_valid && (byte_count_r == '0)))
    else $error("last byte did not produce a verdict or clear the parser");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status <= rihc_pkg::ST_RELOC_BAD))
    else $error("status code out of range");

  a_not_image_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == rihc_pkg::ST_NOT_IMAGE)) |->
      ((out_data.version == 8'd0) && (out_data.code_start == '0) &&
       (out_data.expected_length == '0)))
    else $error("header fields leaked on a not-image verdict");

  a_bad_index_gated: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != rihc_pkg::ST_RELOC_BAD)) |->
      (out_data.bad_reloc_index == 16'd0))
    else $error("bad relocation index reported without relocation fault");

endmodule
`default_nettype wire
